// ===== hdl/interval_minmax_outlier_filter_assert.svh =====
// assertion macros for the interval min/max outlier filter checker
// expects clk and rst_n in the scope where a macro is used
`ifndef INTERVAL_MINMAX_OUTLIER_FILTER_ASSERT_SVH
`define INTERVAL_MINMAX_OUTLIER_FILTER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define IMOF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define IMOF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/imof_pkg.sv =====
// shared types and constants for the interval min/max outlier filter
// no dependencies; used by the top level and its checker
package imof_pkg;

    localparam int SMP_W           = 16;
    localparam int SPI_W           = 20;
    localparam int IDX_OUT_W       = 4;
    localparam int NUM_WINDOWS_DEF = 10;

    localparam logic [SPI_W-1:0]        SPI_RESET = SPI_W'(44100);
    localparam logic signed [SMP_W-1:0] SMP_MAX   = 16'sh7FFF;
    localparam logic signed [SMP_W-1:0] SMP_MIN   = 16'sh8000;

    // result word kinds
    typedef enum logic [1:0] {
        KIND_SUMMARY = 2'd0,
        KIND_MIN     = 2'd1,
        KIND_MAX     = 2'd2
    } kind_t;

endpackage

// ===== hdl/interval_minmax_outlier_filter.sv =====
// interval min/max tracker with a one-sigma filter over the stored extremes
// depends on imof_pkg
//
//   channel   | handshake                   | payload
//   ----------+-----------------------------+-----------------------------------------------
//   sample    | sample_valid / sample_stall | sample
//   result    | result_valid / result_stall | kind, interval_index, value_low, value_high, last
//   cfg       | cfg_valid / cfg_ready       | samples_per_interval
//
// samples that do not end the run stream back to back while the result register is free
// the sample that ends a run starts a walk through the interval memory (one read
// port): N reads for sums, a drain and the bound math, N reads for the test, a drain,
// then a scan that steps over unflagged positions and emits each filtered word
// reset clears all control state; the interval memory needs no clearing pass
// a stalled result word holds the result register; sample_stall rises with it
module interval_minmax_outlier_filter
    import imof_pkg::*;
#(
    parameter int NUM_WINDOWS = NUM_WINDOWS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sample_valid,
    output logic                        sample_stall,
    input  logic signed [SMP_W-1:0]     sample,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [1:0]                  kind,
    output logic [IDX_OUT_W-1:0]        interval_index,
    output logic signed [SMP_W-1:0]     value_low,
    output logic signed [SMP_W-1:0]     value_high,
    output logic                        last,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [SPI_W-1:0]            samples_per_interval
);

    localparam int IDX_W = $clog2(NUM_WINDOWS);
    localparam int CUR_W = $clog2(2 * NUM_WINDOWS);
    localparam int SQ_W  = 2 * SMP_W - 1;
    localparam int SUM_W = SMP_W + 1 + IDX_W;
    localparam int Q_W   = SQ_W + IDX_W;
    localparam int D_W   = SUM_W + 1;
    localparam int CMP_W = 2 * SUM_W;
    localparam int FLG_W = 2 * NUM_WINDOWS;

    localparam logic [IDX_W-1:0]        LAST_IDX = IDX_W'(NUM_WINDOWS - 1);
    localparam logic [CUR_W-1:0]        LAST_CUR = CUR_W'(NUM_WINDOWS - 1);
    localparam logic [CUR_W-1:0]        END_CUR  = CUR_W'(2 * NUM_WINDOWS - 1);
    localparam logic [CUR_W-1:0]        N_CUR    = CUR_W'(NUM_WINDOWS);
    localparam logic signed [D_W-1:0]   N_D      = D_W'(NUM_WINDOWS);
    localparam logic [CMP_W-1:0]        N_C      = CMP_W'(NUM_WINDOWS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM,
        S_SUM_WAIT,
        S_BOUND_MUL,
        S_BOUND_SUB,
        S_TEST,
        S_TEST_WAIT,
        S_EMIT_SCAN,
        S_EMIT_OUT
    } state_t;

    state_t state_reg, state_next;

    // configuration and interval tracking
    logic [SPI_W-1:0]           spi_reg;
    logic [SPI_W-1:0]           count_reg;
    logic [IDX_W-1:0]           icount_reg;
    logic signed [SMP_W-1:0]    min_reg;
    logic signed [SMP_W-1:0]    max_reg;
    logic [CUR_W-1:0]           cursor_reg;

    // result register
    logic                       result_valid_reg;
    kind_t                      kind_reg;
    logic [IDX_OUT_W-1:0]       idx_reg;
    logic signed [SMP_W-1:0]    lo_reg;
    logic signed [SMP_W-1:0]    hi_reg;
    logic                       last_reg;

    // interval memory, {max, min} per entry
    logic [2*SMP_W-1:0]         win_mem [NUM_WINDOWS];
    logic [2*SMP_W-1:0]         rd_data_reg;
    logic                       rd_en;
    logic [IDX_W-1:0]           rd_addr;
    logic                       wr_en;

    // statistics pipeline, lane 0 minima and lane 1 maxima
    logic                       rd_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [IDX_W-1:0]           rd_idx_reg, s2_idx_reg, s3_idx_reg;
    logic signed [SMP_W-1:0]    v2_reg    [2];
    logic [SQ_W-1:0]            sq_reg    [2];
    logic [SUM_W-1:0]           dabs_reg  [2];
    logic [CMP_W-1:0]           dd_reg    [2];
    logic signed [SUM_W-1:0]    s_reg     [2];
    logic [Q_W-1:0]             q_reg     [2];
    logic [CMP_W-1:0]           nq_reg    [2];
    logic [CMP_W-1:0]           ss_reg    [2];
    logic [CMP_W-1:0]           bound_reg [2];
    logic [NUM_WINDOWS-1:0]     flag_reg  [2];

    logic signed [SMP_W-1:0]    lane_v    [2];
    logic signed [2*SMP_W-1:0]  lane_prod [2];
    logic signed [D_W-1:0]      lane_dif  [2];
    logic [SUM_W-1:0]           lane_dabs [2];
    logic [SUM_W-1:0]           lane_sabs [2];

    logic                       smp_acc;
    logic                       out_free;
    logic [SPI_W:0]             cnt_inc;
    logic [SPI_W-1:0]           len;
    logic                       close;
    logic                       run_end;
    logic                       run_start;
    logic signed [SMP_W-1:0]    new_min;
    logic signed [SMP_W-1:0]    new_max;
    logic                       sum_mode;
    logic                       cur_hi;
    logic [IDX_W-1:0]           emit_idx;
    logic [FLG_W-1:0]           all_flags;
    logic [FLG_W-1:0]           rest_flags;
    logic                       flag_hit;
    logic                       emit_last;

    // handshakes
    assign out_free     = !result_valid_reg || !result_stall;
    assign sample_stall = (state_reg != S_IDLE) || !out_free;
    assign smp_acc      = sample_valid && !sample_stall;
    assign cfg_ready    = 1'b1;

    // interval close detection and running extremes
    assign cnt_inc   = {1'b0, count_reg} + (SPI_W + 1)'(1);
    assign len       = (spi_reg == '0) ? SPI_W'(1) : spi_reg;
    assign close     = cnt_inc >= {1'b0, len};
    assign run_end   = close && (icount_reg == LAST_IDX);
    assign run_start = smp_acc && run_end;
    assign new_min   = (sample < min_reg) ? sample : min_reg;
    assign new_max   = (sample > max_reg) ? sample : max_reg;

    // cursor decode for memory walks and emission
    assign sum_mode   = state_reg inside {S_SUM, S_SUM_WAIT};
    assign cur_hi     = cursor_reg >= N_CUR;
    assign emit_idx   = cur_hi ? IDX_W'(cursor_reg - N_CUR) : cursor_reg[IDX_W-1:0];
    assign all_flags  = {flag_reg[1], flag_reg[0]};
    assign rest_flags = all_flags >> cursor_reg;
    assign flag_hit   = all_flags[cursor_reg];
    assign emit_last  = (rest_flags[FLG_W-1:1] == '0);

    // memory port control
    assign wr_en   = smp_acc && close;
    assign rd_addr = emit_idx;
    assign rd_en   = (state_reg inside {S_SUM, S_TEST})
                     || ((state_reg == S_EMIT_SCAN) && flag_hit);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (run_start)
                    state_next = S_SUM;
            end
            S_SUM:
            begin
                if (cursor_reg == LAST_CUR)
                    state_next = S_SUM_WAIT;
            end
            S_SUM_WAIT:
            begin
                if (!rd_vld_reg && !s2_vld_reg)
                    state_next = S_BOUND_MUL;
            end
            S_BOUND_MUL:
            begin
                state_next = S_BOUND_SUB;
            end
            S_BOUND_SUB:
            begin
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (cursor_reg == LAST_CUR)
                    state_next = S_TEST_WAIT;
            end
            S_TEST_WAIT:
            begin
                if (!rd_vld_reg && !s2_vld_reg && !s3_vld_reg)
                    state_next = S_EMIT_SCAN;
            end
            S_EMIT_SCAN:
            begin
                if (flag_hit)
                    state_next = S_EMIT_OUT;
                else if (cursor_reg == END_CUR)
                    state_next = S_IDLE;
            end
            S_EMIT_OUT:
            begin
                if (out_free)
                    state_next = emit_last ? S_IDLE : S_EMIT_SCAN;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state, interval tracking, cursor and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            spi_reg          <= SPI_RESET;
            count_reg        <= '0;
            icount_reg       <= '0;
            min_reg          <= SMP_MAX;
            max_reg          <= SMP_MIN;
            cursor_reg       <= '0;
            result_valid_reg <= 1'b0;
            kind_reg         <= KIND_SUMMARY;
            idx_reg          <= '0;
            lo_reg           <= '0;
            hi_reg           <= '0;
            last_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
                spi_reg <= samples_per_interval;

            // result word drains when taken
            if (!result_stall)
                result_valid_reg <= 1'b0;

            // sample word
            if (smp_acc)
            begin
                if (close)
                begin
                    count_reg        <= '0;
                    min_reg          <= SMP_MAX;
                    max_reg          <= SMP_MIN;
                    icount_reg       <= run_end ? '0 : icount_reg + IDX_W'(1);
                    result_valid_reg <= 1'b1;
                    kind_reg         <= KIND_SUMMARY;
                    idx_reg          <= IDX_OUT_W'(icount_reg);
                    lo_reg           <= new_min;
                    hi_reg           <= new_max;
                    last_reg         <= !run_end;
                end
                else
                begin
                    count_reg <= cnt_inc[SPI_W-1:0];
                    min_reg   <= new_min;
                    max_reg   <= new_max;
                end
            end

            // cursor walks
            case (state_reg)
                S_SUM, S_TEST:
                begin
                    cursor_reg <= (cursor_reg == LAST_CUR) ? '0 : cursor_reg + CUR_W'(1);
                end
                S_EMIT_SCAN:
                begin
                    if (!flag_hit)
                        cursor_reg <= (cursor_reg == END_CUR) ? '0 : cursor_reg + CUR_W'(1);
                end
                S_EMIT_OUT:
                begin
                    if (out_free)
                    begin
                        cursor_reg       <= emit_last ? '0 : cursor_reg + CUR_W'(1);
                        result_valid_reg <= 1'b1;
                        kind_reg         <= cur_hi ? KIND_MAX : KIND_MIN;
                        idx_reg          <= IDX_OUT_W'(emit_idx);
                        lo_reg           <= cur_hi ? '0 : rd_data_reg[SMP_W-1:0];
                        hi_reg           <= cur_hi ? rd_data_reg[2*SMP_W-1:SMP_W] : '0;
                        last_reg         <= emit_last;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // interval memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            win_mem[icount_reg] <= {new_max, new_min};
        if (rd_en)
            rd_data_reg <= win_mem[rd_addr];
    end

    // per-lane arithmetic on the memory read data and the sums
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            lane_v[l]    = rd_data_reg[l*SMP_W +: SMP_W];
            lane_prod[l] = lane_v[l] * lane_v[l];
            lane_dif[l]  = N_D * D_W'(lane_v[l]) - D_W'(s_reg[l]);
            lane_dabs[l] = lane_dif[l][D_W-1] ? SUM_W'(-lane_dif[l]) : SUM_W'(lane_dif[l]);
            lane_sabs[l] = s_reg[l][SUM_W-1] ? SUM_W'(-s_reg[l]) : SUM_W'(s_reg[l]);
        end
    end

    // statistics pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= state_reg inside {S_SUM, S_TEST};
            s2_vld_reg <= rd_vld_reg;
            s3_vld_reg <= s2_vld_reg && !sum_mode;
        end
    end

    // statistics pipeline data: squares, sums, bounds, and the one-sigma test
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_addr;
        s2_idx_reg <= rd_idx_reg;
        s3_idx_reg <= s2_idx_reg;
        for (int l = 0; l < 2; l++)
        begin
            if (rd_vld_reg)
            begin
                v2_reg[l]   <= lane_v[l];
                sq_reg[l]   <= lane_prod[l][SQ_W-1:0];
                dabs_reg[l] <= lane_dabs[l];
            end

            if (run_start)
            begin
                s_reg[l] <= '0;
                q_reg[l] <= '0;
            end
            else if (s2_vld_reg && sum_mode)
            begin
                s_reg[l] <= s_reg[l] + SUM_W'(v2_reg[l]);
                q_reg[l] <= q_reg[l] + Q_W'(sq_reg[l]);
            end

            if (s2_vld_reg && !sum_mode)
                dd_reg[l] <= dabs_reg[l] * dabs_reg[l];

            if (state_reg == S_BOUND_MUL)
            begin
                nq_reg[l] <= CMP_W'(q_reg[l]) * N_C;
                ss_reg[l] <= lane_sabs[l] * lane_sabs[l];
            end

            if (state_reg == S_BOUND_SUB)
                bound_reg[l] <= nq_reg[l] - ss_reg[l];

            if (s3_vld_reg)
                flag_reg[l][s3_idx_reg] <= (dd_reg[l] <= bound_reg[l]);
        end
    end

    // outputs
    assign result_valid   = result_valid_reg;
    assign kind           = kind_reg;
    assign interval_index = idx_reg;
    assign value_low      = lo_reg;
    assign value_high     = hi_reg;
    assign last           = last_reg;

endmodule

// ===== hdl/imof_checker.sv =====
// port-level checker for the interval min/max outlier filter, bound to the top level
// depends on imof_pkg and interval_minmax_outlier_filter_assert.svh
`include "interval_minmax_outlier_filter_assert.svh"

module imof_checker
    import imof_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sample_stall,
    input  logic                        result_valid,
    input  logic                        result_stall,
    input  logic [1:0]                  kind,
    input  logic [IDX_OUT_W-1:0]        interval_index,
    input  logic signed [SMP_W-1:0]     value_low,
    input  logic signed [SMP_W-1:0]     value_high,
    input  logic                        last
);

    // a stalled result word holds
    `IMOF_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(kind) && $stable(interval_index) && $stable(value_low) && $stable(value_high) && $stable(last), "stalled result word changed")

    // filtered words carry only their own extreme
    `IMOF_ASSERT_NOW(a_kind_fields, result_valid, (kind == KIND_SUMMARY) || (kind == KIND_MIN && value_high == '0) || (kind == KIND_MAX && value_low == '0), "bad kind or stray value field")

    // an interval summary never has its minimum above its maximum
    `IMOF_ASSERT_NOW(a_summary_order, result_valid && kind == KIND_SUMMARY, value_low <= value_high, "summary minimum above maximum")

    // no new sample while the current word's results are still coming
    `IMOF_ASSERT_NOW(a_burst_stall, result_valid && !last, sample_stall, "sample taken inside a result burst")

endmodule

bind interval_minmax_outlier_filter imof_checker u_imof_checker (.*);

// ===== tb/tb_interval_minmax_outlier_filter.sv =====
// self-checking testbench for interval_minmax_outlier_filter: directed and random samples
// with a cycle-free predictor of interval summaries and one-sigma filtered extremes
// depends on imof_pkg and the interval_minmax_outlier_filter top level
module tb_interval_minmax_outlier_filter;
    import imof_pkg::*;

    localparam int NUM_WIN   = NUM_WINDOWS_DEF;
    localparam int SETTLE    = 200;

    typedef struct {
        logic [1:0]              kind;
        logic [IDX_OUT_W-1:0]    idx;
        logic signed [SMP_W-1:0] lo;
        logic signed [SMP_W-1:0] hi;
        logic                    last;
    } result_word_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    sample_valid = 1'b0;
    logic                    sample_stall;
    logic signed [SMP_W-1:0] sample = '0;
    logic                    result_valid;
    logic                    result_stall = 1'b0;
    logic [1:0]              kind;
    logic [IDX_OUT_W-1:0]    interval_index;
    logic signed [SMP_W-1:0] value_low;
    logic signed [SMP_W-1:0] value_high;
    logic                    last;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [SPI_W-1:0]        samples_per_interval = SPI_RESET;

    // idle percentages of the two sides
    int unsigned send_idle_pct = 12;
    int unsigned recv_stall_pct = 70;
    int unsigned errors = 0;

    // predictor state
    int unsigned spi_cur;
    int unsigned smp_count;
    int unsigned win_count;
    int          run_min;
    int          run_max;
    int          win_min [NUM_WIN];
    int          win_max [NUM_WIN];
    int          cluster_base;

    result_word_t pending_results [$];

    interval_minmax_outlier_filter #(
        .NUM_WINDOWS (NUM_WIN)
    ) dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .sample_valid         (sample_valid),
        .sample_stall         (sample_stall),
        .sample               (sample),
        .result_valid         (result_valid),
        .result_stall         (result_stall),
        .kind                 (kind),
        .interval_index       (interval_index),
        .value_low            (value_low),
        .value_high           (value_high),
        .last                 (last),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .samples_per_interval (samples_per_interval)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // compare each accepted result word with the oldest expected one
    always @(posedge clk)
    begin
        result_word_t exp_w;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word kind %0d index %0d lo %0d hi %0d",
                         $time, kind, interval_index, value_low, value_high);
                errors++;
            end
            else
            begin
                exp_w = pending_results.pop_front();
                if (kind !== exp_w.kind)
                begin
                    $display("%0t: kind expected %0d actual %0d", $time, exp_w.kind, kind);
                    errors++;
                end
                if (interval_index !== exp_w.idx)
                begin
                    $display("%0t: interval_index expected %0d actual %0d",
                             $time, exp_w.idx, interval_index);
                    errors++;
                end
                if (value_low !== exp_w.lo)
                begin
                    $display("%0t: value_low expected %0d actual %0d",
                             $time, exp_w.lo, value_low);
                    errors++;
                end
                if (value_high !== exp_w.hi)
                begin
                    $display("%0t: value_high expected %0d actual %0d",
                             $time, exp_w.hi, value_high);
                    errors++;
                end
                if (last !== exp_w.last)
                begin
                    $display("%0t: last expected %0d actual %0d", $time, exp_w.last, last);
                    errors++;
                end
            end
        end
    end

    // predictor reset state
    function automatic void clear_tracker();
        spi_cur   = SPI_RESET;
        smp_count = 0;
        win_count = 0;
        run_min   = 32767;
        run_max   = -32768;
    endfunction

    // keep every stored extreme within one standard deviation of the mean
    function automatic void add_in_band(ref result_word_t burst [$], input int vals [NUM_WIN],
                                        input logic [1:0] k);
        longint       s;
        longint       q;
        longint       bound;
        longint       d;
        result_word_t w;
        s = 0;
        q = 0;
        for (int i = 0; i < NUM_WIN; i++)
        begin
            s += vals[i];
            q += longint'(vals[i]) * vals[i];
        end
        bound = NUM_WIN * q - s * s;
        for (int i = 0; i < NUM_WIN; i++)
        begin
            d = NUM_WIN * longint'(vals[i]) - s;
            if (d * d <= bound)
            begin
                w.kind = k;
                w.idx  = IDX_OUT_W'(i);
                w.lo   = (k == KIND_MIN) ? SMP_W'(vals[i]) : '0;
                w.hi   = (k == KIND_MAX) ? SMP_W'(vals[i]) : '0;
                w.last = 1'b0;
                burst.push_back(w);
            end
        end
    endfunction

    // fold one accepted sample into the tracker and queue the words it causes
    function automatic void track_sample(input logic signed [SMP_W-1:0] v);
        int unsigned  len;
        int unsigned  idx;
        result_word_t w;
        result_word_t burst [$];
        len = (spi_cur == 0) ? 1 : spi_cur;
        if (int'(v) < run_min) run_min = v;
        if (int'(v) > run_max) run_max = v;
        smp_count++;
        if (smp_count >= len)
        begin
            idx = (win_count >= NUM_WIN) ? 0 : win_count;
            win_min[idx] = run_min;
            win_max[idx] = run_max;
            w.kind = KIND_SUMMARY;
            w.idx  = IDX_OUT_W'(idx);
            w.lo   = SMP_W'(run_min);
            w.hi   = SMP_W'(run_max);
            w.last = 1'b0;
            burst.push_back(w);
            smp_count = 0;
            run_min   = 32767;
            run_max   = -32768;
            win_count = idx + 1;
            if (win_count >= NUM_WIN)
            begin
                add_in_band(burst, win_min, KIND_MIN);
                add_in_band(burst, win_max, KIND_MAX);
                win_count = 0;
            end
            burst[burst.size()-1].last = 1'b1;
            foreach (burst[i]) pending_results.push_back(burst[i]);
        end
    endfunction

    // send one sample word; valid stays high after acceptance
    task automatic send_sample(input logic signed [SMP_W-1:0] v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= v;
        do @(posedge clk); while (sample_stall);
        track_sample(v);
    endtask

    // drain, let the statistics walk finish, then write the interval length
    task automatic write_interval_length(input logic [SPI_W-1:0] len);
        sample_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_valid            <= 1'b1;
        samples_per_interval <= len;
        do @(posedge clk); while (!cfg_ready);
        spi_cur = len;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // random sample: full range, rail values or a tight cluster
    function automatic logic signed [SMP_W-1:0] pick_sample();
        int unsigned mode;
        int          v;
        mode = $urandom_range(0, 9);
        if (mode < 4)
            return SMP_W'($urandom_range(0, 65535));
        if (mode == 4)
            return $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
        v = cluster_base + int'($urandom_range(0, 400)) - 200;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return SMP_W'(v);
    endfunction

    // random interval length, mostly short so runs close often
    function automatic logic [SPI_W-1:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r < 5)  return SPI_W'(1);
        if (r < 7)  return SPI_W'(2);
        if (r == 7) return SPI_W'(3);
        if (r == 8) return SPI_W'(5);
        return SPI_W'($urandom_range(6, 12));
    endfunction

    // samples at the reset length close no interval
    task automatic test_default_length();
        send_sample(16'sd0);
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
    endtask

    // a long interval cut short by a lower length closes on the next sample
    task automatic test_length_lowered();
        write_interval_length({SPI_W{1'b1}});
        send_sample(-16'sd5);
        send_sample(16'sd7);
        write_interval_length(SPI_W'(2));
        send_sample(16'sd1);
    endtask

    // zero length acts as one; rail and bit pattern samples end the run
    task automatic test_zero_length();
        write_interval_length('0);
        send_sample(SMP_MIN);
        send_sample(SMP_MAX);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        send_sample(SMP_MIN);
        send_sample(SMP_MAX);
    endtask

    // identical extremes: zero spread, every entry passes
    task automatic test_flat_run();
        write_interval_length(SPI_W'(1));
        repeat (NUM_WIN) send_sample(16'sd1234);
    endtask

    // random samples in segments, each with its own interval length
    task automatic test_random_mix(input int n_items, input int unsigned idle_s,
                                   input int unsigned stall_r);
        int sent;
        int seg;
        send_idle_pct  = idle_s;
        recv_stall_pct = stall_r;
        sent = 0;
        while (sent < n_items)
        begin
            write_interval_length(pick_length());
            cluster_base = int'($urandom_range(0, 60000)) - 30000;
            seg = $urandom_range(25, 55);
            for (int i = 0; i < seg && sent < n_items; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    cluster_base = int'($urandom_range(0, 60000)) - 30000;
                send_sample(pick_sample());
                sent++;
            end
        end
    endtask

    // sequence of tests
    initial
    begin
        clear_tracker();
        cluster_base = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_length();
        test_length_lowered();
        test_zero_length();
        test_flat_run();
        test_random_mix(130, 12, 70);
        test_random_mix(130, 70, 12);
        test_random_mix(130, 0, 0);
        sample_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
